// ----- rtl/core/uapq_pkg.sv -----
// shared types and constants for the unsorted array priority queue
`default_nettype none

package uapq_pkg;

    // queue depth and derived widths
    localparam int CAPACITY = 256;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int ENTRY_W  = 9;

    // command codes
    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_PEEK    = 2'd1,
        CMD_EXTRACT = 2'd2,
        CMD_MODIFY  = 2'd3
    } cmd_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // control sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FIND,
        S_RESP
    } state_t;

    // one stored entry
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/unsorted_array_priority_queue.sv -----
// top level of the unsorted array max-priority queue
//
// Input channel (in_valid/in_ready) carries one command beat: insert, peek
// maximum, extract maximum, or modify the priority of the first entry with
// a matching value. Output channel (out_valid/out_ready) returns exactly one
// beat per command: the value found (peek/extract), a status and the entry
// count after the command. Ties on priority go to the oldest entry.
// Entries sit in one single-port-write, registered-read memory in insertion
// order; the sequencer scans it one entry per cycle.
// Insert writes the new entry without a scan; peek scans every stored
// entry; modify scans up to the first match; extract scans every entry,
// then shifts any entries after the maximum down one slot. Empty and full
// failures, and modify on an empty queue, answer without a scan.
// Throughput is one command at a time; the memory read port sets the pace.
// A new command is taken while the previous result still waits in the
// output register; a stalled receiver holds the sequencer in its response
// state until the output register frees up.
// Reset empties the queue at once; memory contents are not cleared.
`default_nettype none

module unsorted_array_priority_queue (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [1:0]                         cmd,
    input  wire logic signed [uapq_pkg::DATA_W-1:0] item_value,
    input  wire logic signed [uapq_pkg::DATA_W-1:0] item_priority,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [uapq_pkg::DATA_W-1:0]      result_value,
    output logic [1:0]                              status,
    output logic [uapq_pkg::ENTRY_W-1:0]            entry_count
);

    localparam int IDX_W = uapq_pkg::IDX_W;
    localparam int CNT_W = uapq_pkg::CNT_W;
    localparam int DW    = uapq_pkg::DATA_W;

    // entry memory
    uapq_pkg::entry_t mem [uapq_pkg::CAPACITY];
    uapq_pkg::entry_t rdata_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    uapq_pkg::entry_t mem_wdata;

    // sequencer state
    uapq_pkg::state_t  state_reg, state_next;
    uapq_pkg::cmd_t    cmd_reg, cmd_next;
    logic signed [DW-1:0] val_reg, val_next;
    logic signed [DW-1:0] pri_reg, pri_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic signed [DW-1:0] best_pri_reg, best_pri_next;
    logic signed [DW-1:0] best_val_reg, best_val_next;
    logic signed [DW-1:0] res_val_reg, res_val_next;
    uapq_pkg::status_t res_status_reg, res_status_next;
    logic              out_load;

    // output register
    logic              out_valid_reg;
    logic signed [DW-1:0] result_value_reg;
    uapq_pkg::status_t status_reg;
    logic [uapq_pkg::ENTRY_W-1:0] entry_count_reg;

    // scan helpers
    logic [IDX_W-1:0]  last_idx;
    logic              is_last;
    logic              take;

    assign last_idx = IDX_W'(count_reg - CNT_W'(1));
    assign is_last  = (scan_idx_reg == last_idx);
    assign take     = (scan_idx_reg == '0) || (rdata_reg.prio > best_pri_reg);

    // memory write port and registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= uapq_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= (out_valid_reg && !out_ready) || out_load;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        val_reg        <= val_next;
        pri_reg        <= pri_next;
        scan_idx_reg   <= scan_idx_next;
        best_idx_reg   <= best_idx_next;
        best_pri_reg   <= best_pri_next;
        best_val_reg   <= best_val_next;
        res_val_reg    <= res_val_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            result_value_reg <= res_val_reg;
            status_reg       <= res_status_reg;
            entry_count_reg  <= uapq_pkg::ENTRY_W'(count_reg);
        end
    end

    // next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        val_next        = val_reg;
        pri_next        = pri_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        best_idx_next   = best_idx_reg;
        best_pri_next   = best_pri_reg;
        best_val_next   = best_val_reg;
        res_val_next    = res_val_reg;
        res_status_next = res_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = scan_idx_reg;
        mem_wdata       = rdata_reg;
        mem_raddr       = scan_idx_reg + IDX_W'(1);
        in_ready        = 1'b0;
        out_load        = 1'b0;

        case (state_reg)
            uapq_pkg::S_IDLE:
            begin
                in_ready  = 1'b1;
                mem_raddr = '0;
                if (in_valid)
                begin
                    cmd_next        = uapq_pkg::cmd_t'(cmd);
                    val_next        = item_value;
                    pri_next        = item_priority;
                    scan_idx_next   = '0;
                    res_val_next    = '0;
                    res_status_next = uapq_pkg::ST_OK;
                    state_next      = uapq_pkg::S_RESP;
                    case (uapq_pkg::cmd_t'(cmd))
                        uapq_pkg::CMD_INSERT:
                        begin
                            if (count_reg == CNT_W'(uapq_pkg::CAPACITY))
                            begin
                                res_status_next = uapq_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we          = 1'b1;
                                mem_waddr       = IDX_W'(count_reg);
                                mem_wdata.value = item_value;
                                mem_wdata.prio  = item_priority;
                                count_next      = count_reg + CNT_W'(1);
                            end
                        end
                        uapq_pkg::CMD_PEEK, uapq_pkg::CMD_EXTRACT:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = uapq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = uapq_pkg::S_SCAN;
                            end
                        end
                        uapq_pkg::CMD_MODIFY:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = uapq_pkg::ST_NOTFOUND;
                            end
                            else
                            begin
                                state_next = uapq_pkg::S_FIND;
                            end
                        end
                        default:
                        begin
                            state_next = uapq_pkg::S_RESP;
                        end
                    endcase
                end
            end

            // one entry per cycle, keep the first highest priority
            uapq_pkg::S_SCAN:
            begin
                scan_idx_next = scan_idx_reg + IDX_W'(1);
                if (take)
                begin
                    best_idx_next = scan_idx_reg;
                    best_pri_next = rdata_reg.prio;
                    best_val_next = rdata_reg.value;
                end
                if (is_last)
                begin
                    res_val_next = best_val_next;
                    state_next   = uapq_pkg::S_RESP;
                    if (cmd_reg == uapq_pkg::CMD_EXTRACT)
                    begin
                        if (best_idx_next == last_idx)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            mem_raddr     = best_idx_next + IDX_W'(1);
                            scan_idx_next = best_idx_next + IDX_W'(1);
                            state_next    = uapq_pkg::S_SHIFT;
                        end
                    end
                end
            end

            // move each later entry down one slot; reads run one ahead of writes
            uapq_pkg::S_SHIFT:
            begin
                mem_we        = 1'b1;
                mem_waddr     = scan_idx_reg - IDX_W'(1);
                mem_wdata     = rdata_reg;
                scan_idx_next = scan_idx_reg + IDX_W'(1);
                if (is_last)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = uapq_pkg::S_RESP;
                end
            end

            // first value match gets the new priority
            uapq_pkg::S_FIND:
            begin
                scan_idx_next = scan_idx_reg + IDX_W'(1);
                if (rdata_reg.value == val_reg)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = scan_idx_reg;
                    mem_wdata.value = rdata_reg.value;
                    mem_wdata.prio  = pri_reg;
                    state_next      = uapq_pkg::S_RESP;
                end
                else if (is_last)
                begin
                    res_status_next = uapq_pkg::ST_NOTFOUND;
                    state_next      = uapq_pkg::S_RESP;
                end
            end

            // hand the result to the output register once it is free
            uapq_pkg::S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = uapq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = uapq_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_value_reg;
    assign status       = status_reg;
    assign entry_count  = entry_count_reg;

    // count never goes past capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(uapq_pkg::CAPACITY))
        else $error("entry count above capacity");

    // shift never reads the slot it writes
    a_shift_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == uapq_pkg::S_SHIFT) |-> (mem_waddr != mem_raddr))
        else $error("shift read and write hit the same entry");

    // a new result beat only comes from the response state
    a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == uapq_pkg::S_RESP))
        else $error("result raised outside the response state");

    // an empty status always reports an empty queue
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == uapq_pkg::ST_EMPTY)) |-> (entry_count_reg == '0))
        else $error("empty status with entries stored");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for the unsorted array max-priority queue
`timescale 1ns / 100ps

module tb_top;

    localparam int CLK_HALF       = 2;
    localparam int RANDOM_ITEMS   = 530;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 600;

    // one command waiting to be driven; hold makes the sender wait for all results first
    typedef struct {
        uapq_pkg::cmd_t                     op;
        logic signed [uapq_pkg::DATA_W-1:0] value;
        logic signed [uapq_pkg::DATA_W-1:0] prio;
        bit                                 hold;
    } queue_cmd_t;

    // one predicted result beat
    typedef struct {
        logic signed [uapq_pkg::DATA_W-1:0] value;
        uapq_pkg::status_t                  st;
        logic [uapq_pkg::ENTRY_W-1:0]       cnt;
    } queue_result_t;

    // stimulus generator phases
    typedef enum int {
        GEN_MIXED,
        GEN_FILL,
        GEN_DRAIN
    } gen_mode_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic [1:0]                         cmd = uapq_pkg::CMD_INSERT;
    logic signed [uapq_pkg::DATA_W-1:0] item_value = '0;
    logic signed [uapq_pkg::DATA_W-1:0] item_priority = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic signed [uapq_pkg::DATA_W-1:0] result_value;
    logic [1:0]                         status;
    logic [uapq_pkg::ENTRY_W-1:0]       entry_count;

    queue_cmd_t    cmd_plan[$];
    queue_result_t expected_results[$];

    // shadow copy of the queue contents
    logic signed [uapq_pkg::DATA_W-1:0] shadow_value[uapq_pkg::CAPACITY];
    logic signed [uapq_pkg::DATA_W-1:0] shadow_prio[uapq_pkg::CAPACITY];
    int                                 shadow_count = 0;

    int plan_count = 0;
    int full_hits = 0;
    int total_items = 0;
    int items_sent = 0;
    int idle_cycles = 0;
    int errors = 0;

    unsorted_array_priority_queue dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .item_value   (item_value),
        .item_priority(item_priority),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .status       (status),
        .entry_count  (entry_count)
    );

    // clock
    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // idle rates follow the progress of the run
    function automatic int sender_idle_pct();
        if (items_sent < total_items / 3)
            return 33;
        else if (items_sent < 2 * total_items / 3)
            return 85;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (items_sent < total_items / 3)
            return 85;
        else if (items_sent < 2 * total_items / 3)
            return 33;
        return 0;
    endfunction

    // small values collide often so modify finds matches
    function automatic logic signed [uapq_pkg::DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return $urandom_range(0, 16) - 8;
        else if (sel < 8)
            return $urandom;
        else if (sel == 8)
            return 32'sh7fffffff;
        return 32'sh80000000;
    endfunction

    // narrow priorities give plenty of ties
    function automatic logic signed [uapq_pkg::DATA_W-1:0] pick_priority();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return $urandom_range(0, 8) - 4;
        else if (sel < 8)
            return $urandom;
        else if (sel == 8)
            return 32'sh7fffffff;
        return 32'sh80000000;
    endfunction

    // append a command and track the fill level it will leave behind
    task automatic plan_cmd(input uapq_pkg::cmd_t op,
                            input logic signed [uapq_pkg::DATA_W-1:0] v,
                            input logic signed [uapq_pkg::DATA_W-1:0] p, input bit hold);
        queue_cmd_t c;
        c.op    = op;
        c.value = v;
        c.prio  = p;
        c.hold  = hold;
        cmd_plan.push_back(c);
        if (op == uapq_pkg::CMD_INSERT)
        begin
            if (plan_count >= uapq_pkg::CAPACITY)
                full_hits++;
            else
                plan_count++;
        end
        else if (op == uapq_pkg::CMD_EXTRACT && plan_count > 0)
            plan_count--;
    endtask

    // apply one command to the shadow queue and queue the result it should give
    task automatic apply_queue_op(input uapq_pkg::cmd_t op,
                                  input logic signed [uapq_pkg::DATA_W-1:0] v,
                                  input logic signed [uapq_pkg::DATA_W-1:0] p);
        queue_result_t r;
        int            best;
        int            k;
        bit            hit;
        r.value = '0;
        r.st    = uapq_pkg::ST_OK;
        hit     = 1'b0;
        case (op)
            uapq_pkg::CMD_INSERT:
            begin
                if (shadow_count >= uapq_pkg::CAPACITY)
                    r.st = uapq_pkg::ST_FULL;
                else
                begin
                    shadow_value[shadow_count] = v;
                    shadow_prio[shadow_count]  = p;
                    shadow_count++;
                end
            end
            uapq_pkg::CMD_PEEK, uapq_pkg::CMD_EXTRACT:
            begin
                if (shadow_count == 0)
                    r.st = uapq_pkg::ST_EMPTY;
                else
                begin
                    // strict compare keeps the oldest entry on ties
                    best = 0;
                    for (k = 1; k < shadow_count; k++)
                        if (shadow_prio[k] > shadow_prio[best])
                            best = k;
                    r.value = shadow_value[best];
                    if (op == uapq_pkg::CMD_EXTRACT)
                    begin
                        for (k = best; k + 1 < shadow_count; k++)
                        begin
                            shadow_value[k] = shadow_value[k + 1];
                            shadow_prio[k]  = shadow_prio[k + 1];
                        end
                        shadow_count--;
                    end
                end
            end
            default:
            begin
                // first match in storage order gets the new priority
                r.st = uapq_pkg::ST_NOTFOUND;
                for (k = 0; k < shadow_count; k++)
                    if (!hit && shadow_value[k] == v)
                    begin
                        shadow_prio[k] = p;
                        hit            = 1'b1;
                        r.st           = uapq_pkg::ST_OK;
                    end
            end
        endcase
        r.cnt = uapq_pkg::ENTRY_W'(shadow_count);
        expected_results.push_back(r);
    endtask

    // command driver
    always @(posedge clk or negedge rst_n)
    begin : drive_cmds
        queue_cmd_t nxt;
        bit         fire;
        bit         send;
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            cmd           <= uapq_pkg::CMD_INSERT;
            item_value    <= '0;
            item_priority <= '0;
        end
        else
        begin
            fire = in_valid && in_ready;
            if (fire)
            begin
                apply_queue_op(uapq_pkg::cmd_t'(cmd), item_value, item_priority);
                items_sent <= items_sent + 1;
            end
            if (!in_valid || fire)
            begin
                send = cmd_plan.size() != 0
                    && $urandom_range(0, 99) >= sender_idle_pct();
                if (send && cmd_plan[0].hold && expected_results.size() != 0)
                    send = 1'b0;
                if (send)
                begin
                    nxt           = cmd_plan.pop_front();
                    cmd           <= nxt.op;
                    item_value    <= nxt.value;
                    item_priority <= nxt.prio;
                end
                in_valid <= send;
            end
        end
    end

    // result monitor, receiver stalls and watchdog
    always @(posedge clk or negedge rst_n)
    begin : check_results
        queue_result_t want;
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat: value=%0d status=%0d count=%0d",
                             $realtime, result_value, status, entry_count);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_value !== want.value)
                    begin
                        $display("%0t: result_value mismatch: expected %0d, got %0d",
                                 $realtime, want.value, result_value);
                        errors++;
                    end
                    if (status !== want.st)
                    begin
                        $display("%0t: status mismatch: expected %s, got %0d",
                                 $realtime, want.st.name(), status);
                        errors++;
                    end
                    if (entry_count !== want.cnt)
                    begin
                        $display("%0t: entry_count mismatch: expected %0d, got %0d",
                                 $realtime, want.cnt, entry_count);
                        errors++;
                    end
                end
            end
            out_ready <= $urandom_range(0, 99) >= receiver_idle_pct();
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles", $realtime, idle_cycles);
                $display("TEST FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus plan, reset and end of run
    initial
    begin : run_test
        gen_mode_t      mode;
        uapq_pkg::cmd_t op;
        int             i;
        int             w;

        // empty queue errors
        plan_cmd(uapq_pkg::CMD_PEEK, 0, 0, 1'b0);
        plan_cmd(uapq_pkg::CMD_EXTRACT, 0, 0, 1'b0);
        plan_cmd(uapq_pkg::CMD_MODIFY, 32'sh80000000, 32'sh7fffffff, 1'b0);
        // extremes of value and priority, ties go to the oldest entry
        plan_cmd(uapq_pkg::CMD_INSERT, 32'sh7fffffff, 32'sh80000000, 1'b1);
        plan_cmd(uapq_pkg::CMD_INSERT, 32'sh80000000, 32'sh80000000, 1'b0);
        plan_cmd(uapq_pkg::CMD_PEEK, 0, 0, 1'b0);
        plan_cmd(uapq_pkg::CMD_INSERT, 0, 32'sh7fffffff, 1'b0);
        plan_cmd(uapq_pkg::CMD_INSERT, -1, 32'sh7fffffff, 1'b0);
        plan_cmd(uapq_pkg::CMD_PEEK, 0, 0, 1'b0);
        plan_cmd(uapq_pkg::CMD_MODIFY, -1, 32'sh7fffffff, 1'b0);
        // modify with no match, then a real one
        plan_cmd(uapq_pkg::CMD_MODIFY, 12345, 7, 1'b0);
        plan_cmd(uapq_pkg::CMD_MODIFY, 32'sh80000000, -5, 1'b0);
        // drain past empty, removals from the middle and the front
        plan_cmd(uapq_pkg::CMD_EXTRACT, 0, 0, 1'b0);
        plan_cmd(uapq_pkg::CMD_EXTRACT, 0, 0, 1'b0);
        plan_cmd(uapq_pkg::CMD_EXTRACT, 0, 0, 1'b0);
        plan_cmd(uapq_pkg::CMD_EXTRACT, 0, 0, 1'b0);
        plan_cmd(uapq_pkg::CMD_EXTRACT, 0, 0, 1'b0);
        // duplicate values: modify hits only the first
        plan_cmd(uapq_pkg::CMD_INSERT, 7, 1, 1'b0);
        plan_cmd(uapq_pkg::CMD_INSERT, 7, 2, 1'b0);
        plan_cmd(uapq_pkg::CMD_INSERT, 3, 50, 1'b0);
        plan_cmd(uapq_pkg::CMD_MODIFY, 7, 100, 1'b0);
        plan_cmd(uapq_pkg::CMD_EXTRACT, 0, 0, 1'b0);
        plan_cmd(uapq_pkg::CMD_PEEK, 0, 0, 1'b0);

        // random part: mixed, then fill past full, then mostly draining
        mode = GEN_MIXED;
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 80)
                mode = GEN_FILL;
            if (mode == GEN_FILL && full_hits >= 3)
                mode = GEN_DRAIN;
            w = $urandom_range(0, 99);
            case (mode)
                GEN_MIXED:
                begin
                    if (plan_count > 12 && w < 35)
                        op = uapq_pkg::CMD_EXTRACT;
                    else if (w < 35)
                        op = uapq_pkg::CMD_INSERT;
                    else if (w < 55)
                        op = uapq_pkg::CMD_PEEK;
                    else if (w < 85)
                        op = uapq_pkg::CMD_EXTRACT;
                    else
                        op = uapq_pkg::CMD_MODIFY;
                end
                GEN_FILL:
                begin
                    if (w < 85)
                        op = uapq_pkg::CMD_INSERT;
                    else if (w < 95)
                        op = uapq_pkg::CMD_MODIFY;
                    else
                        op = uapq_pkg::CMD_PEEK;
                end
                default:
                begin
                    if (w < 70)
                        op = uapq_pkg::CMD_EXTRACT;
                    else if (w < 80)
                        op = uapq_pkg::CMD_PEEK;
                    else if (w < 90)
                        op = uapq_pkg::CMD_MODIFY;
                    else
                        op = uapq_pkg::CMD_INSERT;
                end
            endcase
            plan_cmd(op, pick_value(), pick_priority(), (i % 60) == 0);
        end
        total_items = cmd_plan.size();

        // reset
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // wait for every command to go in and every result to come out
        while (cmd_plan.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
